### hw/rtl/mpct_pkg.sv
// shared types and constants for the mouse packet cursor tracker
// used by every module of the block; depends on nothing
`default_nettype none

package mpct_pkg;

   // field widths
   localparam int RxByteWidth   = 8;
   localparam int ScreenWidth   = 12;
   localparam int CursorWidth   = 8;
   localparam int OutCoordWidth = 12;
   localparam int DeltaWidth    = 9;
   localparam int RspDataWidth  = 32;
   localparam int CsrIndexWidth = 2;

   // register reset values
   localparam logic [ScreenWidth-1:0] ScreenWidthReset  = 12'd1024;
   localparam logic [ScreenWidth-1:0] ScreenHeightReset = 12'd768;
   localparam logic [CursorWidth-1:0] CursorSizeReset   = 8'd32;

   // header bit positions
   localparam int HdrSyncBit  = 3;
   localparam int HdrXSignBit = 4;
   localparam int HdrYSignBit = 5;
   localparam int HdrLeftBit  = 0;

   // depth of the queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      REG_SCREEN_WIDTH  = 2'd0,
      REG_SCREEN_HEIGHT = 2'd1,
      REG_CURSOR_SIZE   = 2'd2
   } csr_reg_type;

   // packet byte position
   typedef enum logic [3:0] {
      POS_HEADER = 4'b0001,
      POS_X_HELD = 4'b0010,
      POS_DONE   = 4'b0100,
      POS_WAIT   = 4'b1000
   } byte_pos_type;

   // one decoded packet
   typedef struct packed {
      logic [DeltaWidth-1:0] dx;
      logic [DeltaWidth-1:0] dy;
      logic                  left_button;
   } move_type;

   // front to queue
   typedef struct packed {
      logic     valid;
      move_type move;
   } move_push_type;

endpackage

`default_nettype wire

### hw/rtl/mpct_front.sv
// front part: accepts mouse bytes, tracks packet sync and builds moves
// depends on mpct_pkg
`default_nettype none

module mpct_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [mpct_pkg::RxByteWidth-1:0] req_tdata,  // [7:0] rx_byte
   input  wire logic                            queue_full,
   output mpct_pkg::move_push_type              push
);

   mpct_pkg::byte_pos_type                state_ff, state_in;
   logic [mpct_pkg::RxByteWidth-1:0]      header_ff, header_in;
   logic [mpct_pkg::RxByteWidth-1:0]      x_byte_ff, x_byte_in;
   logic                                  accept;

   // a byte is taken whenever the queue has room
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // packet sync
   always_comb begin
      state_in   = state_ff;
      header_in  = header_ff;
      x_byte_in  = x_byte_ff;
      push.valid = 1'b0;
      // move payload from the held bytes and the current y byte
      push.move.dx          = {header_ff[mpct_pkg::HdrXSignBit], x_byte_ff};
      push.move.dy          = {header_ff[mpct_pkg::HdrYSignBit], req_tdata};
      push.move.left_button = header_ff[mpct_pkg::HdrLeftBit];
      if (accept) begin
         if (req_tdata[mpct_pkg::HdrSyncBit]) begin
            header_in = req_tdata;
            state_in  = mpct_pkg::POS_HEADER;
         end else begin
            case (state_ff)
               mpct_pkg::POS_HEADER: begin
                  x_byte_in = req_tdata;
                  state_in  = mpct_pkg::POS_X_HELD;
               end
               mpct_pkg::POS_X_HELD: begin
                  state_in   = mpct_pkg::POS_DONE;
                  push.valid = 1'b1;
               end
               default: begin
                  state_in = mpct_pkg::POS_WAIT;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mpct_pkg::POS_HEADER;
         header_ff <= '0;
         x_byte_ff <= '0;
      end else begin
         state_ff  <= state_in;
         header_ff <= header_in;
         x_byte_ff <= x_byte_in;
      end
   end

   // a move leaves only on an accepted y byte
   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (accept && !req_tdata[mpct_pkg::HdrSyncBit]))
      else $error("move pushed without an accepted y byte");

   // a header always resyncs the packet
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tdata[mpct_pkg::HdrSyncBit]) |=> (state_ff == mpct_pkg::POS_HEADER))
      else $error("header did not restart the packet");

   // a push is never made into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !queue_full)
      else $error("push into full queue");

endmodule

`default_nettype wire

### hw/rtl/mpct_queue.sv
// short queue of decoded moves between front and back
// depends on mpct_pkg
`default_nettype none

module mpct_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mpct_pkg::move_push_type push,
   output logic                        full,
   output logic                        head_valid,
   output mpct_pkg::move_type          head,
   input  wire logic                   pop
);

   mpct_pkg::move_type                 slots_ff [mpct_pkg::QueueDepth];
   logic [mpct_pkg::QueuePtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mpct_pkg::QueuePtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mpct_pkg::QueueCntW-1:0]     count_ff, count_in;

   assign full       = (count_ff == mpct_pkg::QueueCntW'(mpct_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head       = slots_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots_ff[wr_ptr_ff] <= push.move;
      end
   end

   // occupancy stays within the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= mpct_pkg::QueueCntW'(mpct_pkg::QueueDepth))
      else $error("queue count beyond depth");

   // never pop an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   // count goes up on a push without a pop
   assert property (@(posedge clock) disable iff (reset)
      (push.valid && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

`default_nettype wire

### hw/rtl/mpct_back.sv
// back part: applies moves to the cursor, clamps to screen and holds the result
// depends on mpct_pkg
`default_nettype none

module mpct_back #(
   parameter int COORD_WIDTH = 12
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             head_valid,
   input  wire mpct_pkg::move_type               head,
   output logic                                  pop,
   input  wire logic [mpct_pkg::ScreenWidth-1:0] screen_width,
   input  wire logic [mpct_pkg::ScreenWidth-1:0] screen_height,
   input  wire logic [mpct_pkg::CursorWidth-1:0] cursor_size,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [mpct_pkg::RspDataWidth-1:0]     rsp_tdata
);

   localparam int CalcW = ((COORD_WIDTH > mpct_pkg::ScreenWidth) ?
                           COORD_WIDTH : mpct_pkg::ScreenWidth) + 2;

   logic [COORD_WIDTH-1:0]               pos_x_ff, pos_x_in;
   logic [COORD_WIDTH-1:0]               pos_y_ff, pos_y_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [mpct_pkg::RspDataWidth-1:0]    rsp_data_ff, rsp_data_in;
   logic signed [CalcW-1:0]              bound_x, bound_y;
   logic signed [CalcW-1:0]              move_x, move_y;
   logic signed [CalcW-1:0]              clamp_x, clamp_y;
   logic [CalcW-1:0]                     wide_x, wide_y;

   // add a move and clamp into 0 .. bound
   function automatic logic signed [CalcW-1:0] clamp_move(
      input logic [COORD_WIDTH-1:0] pos,
      input logic signed [CalcW-1:0] move,
      input logic signed [CalcW-1:0] bound
   );
      logic signed [CalcW-1:0] sum;
      logic signed [CalcW-1:0] lim;
      sum = $signed(CalcW'(pos)) + move;
      lim = (bound < 0) ? '0 : bound;
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > lim) begin
         sum = lim;
      end
      return sum;
   endfunction

   // bounds and signed moves; y goes against the mouse
   assign bound_x = $signed(CalcW'(screen_width)) - $signed(CalcW'(cursor_size));
   assign bound_y = $signed(CalcW'(screen_height)) - $signed(CalcW'(cursor_size));
   assign move_x  = CalcW'($signed(head.dx));
   assign move_y  = -CalcW'($signed(head.dy));
   assign clamp_x = clamp_move(pos_x_ff, move_x, bound_x);
   assign clamp_y = clamp_move(pos_y_ff, move_y, bound_y);

   // take the next move when the output slot frees up
   assign pop = head_valid && (!rsp_valid_ff || rsp_tready);

   assign wide_x = CalcW'(pos_x_in);
   assign wide_y = CalcW'(pos_y_in);

   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         pos_x_in     = clamp_x[COORD_WIDTH-1:0];
         pos_y_in     = clamp_y[COORD_WIDTH-1:0];
         rsp_valid_in = 1'b1;
         rsp_data_in  = mpct_pkg::RspDataWidth'({head.left_button,
                                                 wide_y[mpct_pkg::OutCoordWidth-1:0],
                                                 wide_x[mpct_pkg::OutCoordWidth-1:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a move is taken only into a free or draining output slot
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (!rsp_valid_ff || rsp_tready))
      else $error("move taken over a waiting result");

   // the cursor moves only when a move is applied
   assert property (@(posedge clock) disable iff (reset)
      !pop |=> ($stable(pos_x_ff) && $stable(pos_y_ff)))
      else $error("cursor moved without a packet");

   // every applied move shows up as a result
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("applied move produced no result");

endmodule

`default_nettype wire

### hw/rtl/mouse_packet_cursor_tracker.sv
// top level of the mouse packet cursor tracker: config registers and the
// front, queue and back parts; depends on mpct_pkg, mpct_front, mpct_queue, mpct_back
//
//  channel  dir  handshake            payload
//  req_     in   req_tvalid/tready    tdata[7:0] rx_byte
//  rsp_     out  rsp_tvalid/tready    tdata[11:0] cursor_x, [23:12] cursor_y,
//                                     [24] left_button, [31:25] zero
//  csr_     in   csr_valid/ready      csr_index register, csr_data value
//
// one byte per cycle is accepted while the two-entry move queue has room
// the result of a packet is registered in the move queue and then in the back part's output
// register, after the combinational add and clamp of the back part
// a stalled result holds the back part; the front keeps taking bytes until
// the queue fills
// reset brings the registers to 1024 by 768 with a 32 pixel cursor at 0,0
`default_nettype none

module mouse_packet_cursor_tracker #(
   parameter int COORD_WIDTH = 12
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [mpct_pkg::RxByteWidth-1:0]   req_tdata,  // [7:0] rx_byte
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [11:0] cursor_x, [23:12] cursor_y, [24] left_button, [31:25] zero
   output logic [mpct_pkg::RspDataWidth-1:0]       rsp_tdata,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mpct_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [mpct_pkg::ScreenWidth-1:0]   csr_data
);

   logic [mpct_pkg::ScreenWidth-1:0] screen_width_ff;
   logic [mpct_pkg::ScreenWidth-1:0] screen_height_ff;
   logic [mpct_pkg::CursorWidth-1:0] cursor_size_ff;
   mpct_pkg::move_push_type          push;
   mpct_pkg::move_type               head;
   logic                             queue_full;
   logic                             head_valid;
   logic                             pop;

   // configuration writes always complete
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= mpct_pkg::ScreenWidthReset;
         screen_height_ff <= mpct_pkg::ScreenHeightReset;
         cursor_size_ff   <= mpct_pkg::CursorSizeReset;
      end else if (csr_valid && csr_ready) begin
         case (mpct_pkg::csr_reg_type'(csr_index))
            mpct_pkg::REG_SCREEN_WIDTH: begin
               screen_width_ff <= csr_data;
            end
            mpct_pkg::REG_SCREEN_HEIGHT: begin
               screen_height_ff <= csr_data;
            end
            mpct_pkg::REG_CURSOR_SIZE: begin
               cursor_size_ff <= csr_data[mpct_pkg::CursorWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   mpct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push)
   );

   mpct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   mpct_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .cursor_size   (cursor_size_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

`default_nettype wire

### bench/testbench.sv
// self-checking bench for the mouse packet cursor tracker: drives ps/2 byte streams,
// tracks packet sync and cursor position alongside the block and checks every report
// depends on mpct_pkg and mouse_packet_cursor_tracker
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CoordW      = mpct_pkg::OutCoordWidth;
   localparam int RxW         = mpct_pkg::RxByteWidth;
   localparam int ScrW        = mpct_pkg::ScreenWidth;
   localparam int DrainCycles = 8;
   localparam int HoldCycles  = 300;

   typedef struct packed {
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic              left;
   } cursor_report_type;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [RxW-1:0]           req_tdata  = '0;  // [7:0] rx_byte
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [11:0] cursor_x, [23:12] cursor_y, [24] left_button, [31:25] zero
   logic [mpct_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   mpct_pkg::csr_reg_type    csr_index  = mpct_pkg::REG_SCREEN_WIDTH;
   logic [ScrW-1:0]          csr_data   = '0;

   // bytes waiting to be sent and cursor reports waiting to arrive
   logic [RxW-1:0]           rx_backlog[$];
   cursor_report_type        cursor_expected[$];

   // idle behavior of each side, changed per phase
   logic                     send_gaps_on = 1'b1;
   logic                     recv_gaps_on = 1'b1;

   int                       error_count     = 0;
   int                       packets_checked = 0;
   int                       send_gap        = 0;
   int                       rsp_wait        = 0;

   // tracker copy of the registers and the packet state
   logic [ScrW-1:0]                    scr_w    = mpct_pkg::ScreenWidthReset;
   logic [ScrW-1:0]                    scr_h    = mpct_pkg::ScreenHeightReset;
   logic [mpct_pkg::CursorWidth-1:0]   cur_size = mpct_pkg::CursorSizeReset;
   mpct_pkg::byte_pos_type             pkt_phase  = mpct_pkg::POS_HEADER;
   logic [RxW-1:0]                     hdr_held   = '0;
   logic [RxW-1:0]                     xbyte_held = '0;
   logic [CoordW-1:0]                  cur_x = '0;
   logic [CoordW-1:0]                  cur_y = '0;

   mouse_packet_cursor_tracker #(.COORD_WIDTH(CoordW)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // move one coordinate and keep it inside 0 .. screen - cursor
   function automatic logic [CoordW-1:0] clamp_coord(input logic [CoordW-1:0] at,
                                                     input int move,
                                                     input logic [ScrW-1:0] span);
      int lim;
      int cs;
      int v;
      lim = span;
      cs  = cur_size;
      lim = lim - cs;
      v   = at;
      v   = v + move;
      if (lim < 0) lim = 0;
      if (v < 0) v = 0;
      if (v > lim) v = lim;
      return v[CoordW-1:0];
   endfunction

   // packet sync and cursor update for one accepted byte
   function automatic void track_packet_byte(input logic [RxW-1:0] rx);
      int                dx;
      int                dy;
      cursor_report_type rep;
      if (rx[mpct_pkg::HdrSyncBit]) begin
         // a sync bit always restarts the packet
         hdr_held  = rx;
         pkt_phase = mpct_pkg::POS_HEADER;
      end else if (pkt_phase == mpct_pkg::POS_HEADER) begin
         xbyte_held = rx;
         pkt_phase  = mpct_pkg::POS_X_HELD;
      end else if (pkt_phase != mpct_pkg::POS_X_HELD) begin
         // stray byte past the end of a packet
         pkt_phase = mpct_pkg::POS_WAIT;
      end else begin
         pkt_phase = mpct_pkg::POS_DONE;
         dx    = $signed({hdr_held[mpct_pkg::HdrXSignBit], xbyte_held});
         dy    = $signed({hdr_held[mpct_pkg::HdrYSignBit], rx});
         cur_x = clamp_coord(cur_x, dx, scr_w);
         cur_y = clamp_coord(cur_y, -dy, scr_h);
         rep.x    = cur_x;
         rep.y    = cur_y;
         rep.left = hdr_held[mpct_pkg::HdrLeftBit];
         cursor_expected.push_back(rep);
      end
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) track_packet_byte(req_tdata);
         if (req_tvalid && !req_tready) begin
            // hold the offered transaction
         end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (rx_backlog.size() != 0) begin
            req_tdata  <= rx_backlog.pop_front();
            req_tvalid <= 1'b1;
            send_gap = send_gaps_on ? $urandom_range(0, 10) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // report monitor and checker
   always @(posedge clock) begin
      cursor_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cursor_expected.size() == 0) begin
               $error("unexpected report: tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = cursor_expected.pop_front();
               if (rsp_tdata[11:0] !== want.x) begin
                  $error("cursor_x: expected %0d, actual %0d", want.x, rsp_tdata[11:0]);
                  error_count++;
               end
               if (rsp_tdata[23:12] !== want.y) begin
                  $error("cursor_y: expected %0d, actual %0d", want.y, rsp_tdata[23:12]);
                  error_count++;
               end
               if (rsp_tdata[24] !== want.left) begin
                  $error("left_button: expected %0d, actual %0d", want.left, rsp_tdata[24]);
                  error_count++;
               end
               if (rsp_tdata[31:25] !== '0) begin
                  $error("padding: expected 0, actual %h", rsp_tdata[31:25]);
                  error_count++;
               end
            end
            packets_checked++;
            // long hold-offs so the front fills and stalls its input
            if (packets_checked == 50 || packets_checked == 400) rsp_wait = HoldCycles;
            else rsp_wait = recv_gaps_on ? $urandom_range(0, 10) : 0;
         end else if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
         end
         rsp_tready <= (rsp_wait == 0);
      end
   end

   // one register write transaction, issued from a rising edge; valid stays up
   task automatic write_reg(input mpct_pkg::csr_reg_type idx, input logic [ScrW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mpct_pkg::REG_SCREEN_WIDTH:  scr_w = val;
         mpct_pkg::REG_SCREEN_HEIGHT: scr_h = val;
         mpct_pkg::REG_CURSOR_SIZE:   cur_size = val[mpct_pkg::CursorWidth-1:0];
         default: ;
      endcase
   endtask

   // wait until every byte is sent and every report has arrived
   task automatic wait_drained();
      while (rx_backlog.size() != 0 || req_tvalid || cursor_expected.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // data byte with the sync bit clear, often a small move
   function automatic logic [RxW-1:0] motion_byte();
      logic [RxW-1:0] b;
      if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 7);
      else b = 8'($urandom);
      b[mpct_pkg::HdrSyncBit] = 1'b0;
      return b;
   endfunction

   // mostly whole packets, with noise, stray and cut-short packets mixed in
   task automatic queue_random_bytes(input int count);
      int             n;
      int             r;
      logic [RxW-1:0] hdr;
      n = 0;
      while (n < count) begin
         r   = $urandom_range(0, 99);
         hdr = 8'($urandom);
         hdr[mpct_pkg::HdrSyncBit] = 1'b1;
         if (r < 80) begin
            rx_backlog.push_back(hdr);
            rx_backlog.push_back(motion_byte());
            rx_backlog.push_back(motion_byte());
            n += 3;
         end else if (r < 88) begin
            rx_backlog.push_back(8'($urandom));
            n += 1;
         end else if (r < 94) begin
            rx_backlog.push_back(motion_byte());
            n += 1;
         end else begin
            rx_backlog.push_back(hdr);
            n += 1;
            if (r[0]) begin
               rx_backlog.push_back(motion_byte());
               n += 1;
            end
         end
      end
   endtask

   // reset, directed bytes, then register settings with random traffic
   initial begin : stimulus
      int              phase;
      logic [ScrW-1:0] w;
      logic [ScrW-1:0] h;
      logic [ScrW-1:0] cs;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // bytes before any header, then stray bytes past the packet
      rx_backlog.push_back(8'h05);
      rx_backlog.push_back(8'h03);
      rx_backlog.push_back(8'h07);
      rx_backlog.push_back(8'h00);
      // both signs and left button, largest negative moves
      rx_backlog.push_back(8'h39);
      rx_backlog.push_back(8'h00);
      rx_backlog.push_back(8'h00);
      // header restart in the middle of a packet
      rx_backlog.push_back(8'h09);
      rx_backlog.push_back(8'h10);
      rx_backlog.push_back(8'h0A);
      rx_backlog.push_back(8'hF7);
      rx_backlog.push_back(8'h01);
      // largest positive moves up to the right edge
      rx_backlog.push_back(8'h0B);
      rx_backlog.push_back(8'hF7);
      rx_backlog.push_back(8'hF7);
      rx_backlog.push_back(8'h08);
      rx_backlog.push_back(8'hF7);
      rx_backlog.push_back(8'hF0);
      rx_backlog.push_back(8'h08);
      rx_backlog.push_back(8'hF7);
      rx_backlog.push_back(8'h00);
      rx_backlog.push_back(8'h08);
      rx_backlog.push_back(8'h77);
      rx_backlog.push_back(8'h00);
      // all-ones header
      rx_backlog.push_back(8'hFF);
      rx_backlog.push_back(8'h80);
      rx_backlog.push_back(8'h80);

      for (phase = 0; phase < 8; phase++) begin
         wait_drained();
         case (phase)
            0: begin w = 12'd4095; h = 12'd4095; cs = 12'd0;   end
            1: begin w = 12'd1;    h = 12'd1;    cs = 12'd255; end
            2: begin w = 12'd1;    h = 12'd1;    cs = 12'd0;   end
            3: begin w = 12'd40;   h = 12'd30;   cs = 12'd32;  end
            4: begin w = 12'd4095; h = 12'd4095; cs = 12'd255; end
            5: begin w = 12'd300;  h = 12'd200;  cs = 12'd16;  end
            default: begin
               w  = $urandom_range(1, 4095);
               h  = $urandom_range(1, 4095);
               cs = $urandom_range(0, 255);
            end
         endcase
         @(posedge clock);
         write_reg(mpct_pkg::REG_SCREEN_WIDTH, w);
         write_reg(mpct_pkg::REG_SCREEN_HEIGHT, h);
         write_reg(mpct_pkg::REG_CURSOR_SIZE, cs);
         csr_valid <= 1'b0;
         @(negedge clock);
         send_gaps_on <= phase[0];
         recv_gaps_on <= phase[1];
         queue_random_bytes(240);
      end

      wait_drained();
      if (error_count == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

### files.f
hw/rtl/mpct_pkg.sv
hw/rtl/mpct_front.sv
hw/rtl/mpct_queue.sv
hw/rtl/mpct_back.sv
hw/rtl/mouse_packet_cursor_tracker.sv
bench/testbench.sv
